>>> src/lps_pkg.sv
package lps_pkg;

   localparam int NUM_CHANNELS   = 8;
   localparam int PATTERN_GROUPS = 256;
   localparam int QUEUE_DEPTH    = 2;

   localparam int FUNC_W     = 2;
   localparam int CHAN_IN_W  = 3;
   localparam int GROUP_IN_W = 8;
   localparam int INTERVAL_W = 32;
   localparam int OUT_W      = 8;

   localparam int CHAN_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CHAN_PAD_W = (CHAN_W > CHAN_IN_W) ? CHAN_W : CHAN_IN_W;
   localparam int GROUP_W    = $clog2(PATTERN_GROUPS);
   localparam int SHOWN_CHANNELS = (NUM_CHANNELS < OUT_W) ? NUM_CHANNELS : OUT_W;
   localparam int GROUP_ENTRIES  = 2 ** GROUP_IN_W;

   localparam logic [INTERVAL_W-1:0] STOP_MARK = 32'hFFFF_FFFF;

   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_START,
      OP_WRITE,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_STEP,
      BK_LOAD,
      BK_REPLY
   } back_state_type;

   typedef struct packed {
      op_type                  op;
      logic [CHAN_W-1:0]       channel;
      logic [GROUP_W-1:0]      group;
      logic                    level;
      logic [INTERVAL_W-1:0]   interval;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic                  level;
      logic [INTERVAL_W-1:0] interval;
   } group_type;

   localparam int GROUP_BITS = $bits(group_type);

   typedef logic [GROUP_W-1:0] wrap_table_type [GROUP_ENTRIES];

   // Maps every possible group field value onto a pattern memory address.
   function automatic wrap_table_type build_wrap_table();
      wrap_table_type t;
      for (int i = 0; i < GROUP_ENTRIES; i++) begin
         t[i] = GROUP_W'(i % PATTERN_GROUPS);
      end
      return t;
   endfunction

   localparam wrap_table_type WRAP_TABLE = build_wrap_table();

   function automatic logic [GROUP_W-1:0] next_group(input logic [GROUP_W-1:0] g);
      logic [GROUP_W-1:0] n;
      if (g == GROUP_W'(PATTERN_GROUPS - 1)) begin
         n = '0;
      end else begin
         n = g + 1'b1;
      end
      return n;
   endfunction

endpackage

>>> src/lps_ram.sv
module lps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lps_front.sv
module lps_front (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lps_pkg::FUNC_W-1:0]       req_func,
   input  logic [lps_pkg::CHAN_IN_W-1:0]    req_channel,
   input  logic [lps_pkg::GROUP_IN_W-1:0]   req_group_index,
   input  logic                             req_level,
   input  logic [lps_pkg::INTERVAL_W-1:0]   req_interval_ms,
   input  lps_pkg::queue_status_type        q_status,
   output lps_pkg::push_type                push
);
   import lps_pkg::*;

   logic [CHAN_PAD_W-1:0] chan_wide;
   logic                  chan_ok;

   assign req_stall = q_status.full;
   assign chan_wide = CHAN_PAD_W'(req_channel);
   assign chan_ok   = int'(req_channel) < NUM_CHANNELS;

   always_comb begin
      push.push          = req_valid && !q_status.full;
      push.item.channel  = chan_wide[CHAN_W-1:0];
      push.item.group    = WRAP_TABLE[req_group_index];
      push.item.level    = req_level;
      push.item.interval = req_interval_ms;
      unique case (req_func)
         FUNC_TICK:  push.item.op = OP_TICK;
         // A start on a channel that does not exist only returns the result.
         FUNC_START: push.item.op = chan_ok ? OP_START : OP_NOP;
         FUNC_WRITE: push.item.op = OP_WRITE;
         FUNC_NONE:  push.item.op = OP_NOP;
      endcase
   end

endmodule

>>> src/lps_queue.sv
module lps_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  lps_pkg::push_type          push,
   input  logic                       pop,
   output lps_pkg::item_type          head,
   output lps_pkg::queue_status_type  q_status
);
   import lps_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.valid = count_ff != '0;
   assign q_status.full  = count_ff == COUNT_W'(QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = push.push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

>>> src/lps_back.sv
module lps_back (
   input  logic                        clock,
   input  logic                        reset,
   input  lps_pkg::item_type           head,
   input  lps_pkg::queue_status_type   q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lps_pkg::OUT_W-1:0]   rsp_levels,
   output logic [lps_pkg::OUT_W-1:0]   rsp_active_mask
);
   import lps_pkg::*;

   back_state_type          state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [CHAN_W-1:0]       chan_ff, chan_in;
   logic [NUM_CHANNELS-1:0] active_ff, active_in;
   logic [NUM_CHANNELS-1:0] has_ff, has_in;
   logic [NUM_CHANNELS-1:0] repeat_ff, repeat_in;
   logic [NUM_CHANNELS-1:0] level_ff, level_in;
   logic [GROUP_W-1:0]      base_ff [NUM_CHANNELS];
   logic [GROUP_W-1:0]      base_in [NUM_CHANNELS];
   logic [GROUP_W-1:0]      pointer_ff [NUM_CHANNELS];
   logic [GROUP_W-1:0]      pointer_in [NUM_CHANNELS];
   logic [INTERVAL_W-1:0]   interval_ff [NUM_CHANNELS];
   logic [INTERVAL_W-1:0]   interval_in [NUM_CHANNELS];
   logic [INTERVAL_W-1:0]   elapsed_ff [NUM_CHANNELS];
   logic [INTERVAL_W-1:0]   elapsed_in [NUM_CHANNELS];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]        rsp_levels_ff, rsp_levels_in;
   logic [OUT_W-1:0]        rsp_active_ff, rsp_active_in;

   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [GROUP_W-1:0]      ram_rd_addr;
   group_type               ram_wr_data;
   group_type               ram_rd_data;

   logic [CHAN_W-1:0]       ch_idx;
   logic [INTERVAL_W-1:0]   elapsed_inc;
   logic                    due;
   logic                    last_chan;
   logic                    repeat_hit;
   logic                    reload;
   logic                    rsp_free;

   assign ram_wr_data.level    = head.level;
   assign ram_wr_data.interval = head.interval;

   lps_ram #(
      .WIDTH(GROUP_BITS),
      .DEPTH(PATTERN_GROUPS)
   ) u_pattern_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(head.group),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // While idle the channel comes from the queue head, otherwise from the scan counter.
   assign ch_idx      = (state_ff == BK_IDLE) ? head.channel : chan_ff;
   assign elapsed_inc = (elapsed_ff[ch_idx] == STOP_MARK) ? STOP_MARK
                                                          : elapsed_ff[ch_idx] + 1'b1;
   assign due         = elapsed_inc >= interval_ff[ch_idx];
   assign last_chan   = chan_ff == CHAN_W'(NUM_CHANNELS - 1);
   assign repeat_hit  = has_ff[ch_idx] && (base_ff[ch_idx] == head.group);
   assign reload      = (ram_rd_data.interval == '0) ||
                        ((ram_rd_data.interval == STOP_MARK) && repeat_ff[ch_idx]);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_status.valid) begin
               unique case (head.op)
                  OP_TICK:  state_in = BK_SCAN;
                  OP_START: state_in = repeat_hit ? BK_REPLY : BK_LOAD;
                  OP_WRITE: state_in = BK_REPLY;
                  OP_NOP:   state_in = BK_REPLY;
               endcase
            end
         end
         BK_SCAN: begin
            if (active_ff[ch_idx] && due) begin
               state_in = BK_STEP;
            end else if (last_chan) begin
               state_in = BK_REPLY;
            end
         end
         BK_STEP: begin
            if (reload) begin
               state_in = BK_LOAD;
            end else if (last_chan) begin
               state_in = BK_REPLY;
            end else begin
               state_in = BK_SCAN;
            end
         end
         BK_LOAD: begin
            state_in = ((op_ff == OP_TICK) && !last_chan) ? BK_SCAN : BK_REPLY;
         end
         BK_REPLY: begin
            if (rsp_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop           = 1'b0;
      op_in         = op_ff;
      chan_in       = chan_ff;
      active_in     = active_ff;
      has_in        = has_ff;
      repeat_in     = repeat_ff;
      level_in      = level_ff;
      base_in       = base_ff;
      pointer_in    = pointer_ff;
      interval_in   = interval_ff;
      elapsed_in    = elapsed_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = pointer_ff[ch_idx];
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_levels_in = rsp_levels_ff;
      rsp_active_in = rsp_active_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_status.valid) begin
               pop   = 1'b1;
               op_in = head.op;
               unique case (head.op)
                  OP_TICK: begin
                     chan_in = '0;
                  end
                  OP_START: begin
                     chan_in = head.channel;
                     if (repeat_hit) begin
                        repeat_in[ch_idx] = 1'b1;
                     end else begin
                        base_in[ch_idx]    = head.group;
                        has_in[ch_idx]     = 1'b1;
                        active_in[ch_idx]  = 1'b1;
                        elapsed_in[ch_idx] = '0;
                        ram_rd_en          = 1'b1;
                        ram_rd_addr        = head.group;
                     end
                  end
                  OP_WRITE: begin
                     ram_wr_en = 1'b1;
                  end
                  OP_NOP: begin
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (active_ff[ch_idx] && due) begin
               elapsed_in[ch_idx] = '0;
               ram_rd_en          = 1'b1;
            end else begin
               if (active_ff[ch_idx]) begin
                  elapsed_in[ch_idx] = elapsed_inc;
               end
               if (!last_chan) begin
                  chan_in = chan_ff + 1'b1;
               end
            end
         end
         BK_STEP: begin
            pointer_in[ch_idx] = next_group(pointer_ff[ch_idx]);
            if (reload) begin
               // A loop mark or a stop mark with a pending repeat pass
               // reloads the start group.
               ram_rd_en   = 1'b1;
               ram_rd_addr = base_ff[ch_idx];
               if (ram_rd_data.interval == STOP_MARK) begin
                  repeat_in[ch_idx] = 1'b0;
               end
            end else begin
               level_in[ch_idx] = ram_rd_data.level;
               if (ram_rd_data.interval == STOP_MARK) begin
                  active_in[ch_idx] = 1'b0;
                  has_in[ch_idx]    = 1'b0;
               end else begin
                  interval_in[ch_idx] = ram_rd_data.interval;
               end
               if (!last_chan) begin
                  chan_in = chan_ff + 1'b1;
               end
            end
         end
         BK_LOAD: begin
            level_in[ch_idx]    = ram_rd_data.level;
            interval_in[ch_idx] = ram_rd_data.interval;
            pointer_in[ch_idx]  = next_group(base_ff[ch_idx]);
            if ((op_ff == OP_TICK) && !last_chan) begin
               chan_in = chan_ff + 1'b1;
            end
         end
         BK_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_levels_in = '0;
               rsp_active_in = '0;
               for (int i = 0; i < SHOWN_CHANNELS; i++) begin
                  rsp_levels_in[i] = level_ff[i];
                  rsp_active_in[i] = active_ff[i];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         chan_ff      <= '0;
         active_ff    <= '0;
         has_ff       <= '0;
         repeat_ff    <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            base_ff[i]     <= '0;
            pointer_ff[i]  <= '0;
            interval_ff[i] <= '0;
            elapsed_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         active_ff    <= active_in;
         has_ff       <= has_in;
         repeat_ff    <= repeat_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         pointer_ff   <= pointer_in;
         interval_ff  <= interval_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rsp_levels_ff <= rsp_levels_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_levels      = rsp_levels_ff;
   assign rsp_active_mask = rsp_active_ff;

endmodule

>>> src/led_pattern_sequencer.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   func, channel, group_index, level, interval_ms
// rsp      out        rsp_valid/rsp_stall   levels, active_mask
//
// Each item yields one result. A write or an idle code passes the idle and reply states
// of the back end, a start also the load state unless it repeats. A tick scans every
// channel, with a step for every channel that is due and a load for every reload of a
// start group: the channel scan shares the single read port of the pattern memory.
// Reset is synchronous and clears every channel at once; pattern memory is not cleared.
// A two-entry queue keeps requests flowing while the result register waits out a stall.
module led_pattern_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lps_pkg::FUNC_W-1:0]       req_func,
   input  logic [lps_pkg::CHAN_IN_W-1:0]    req_channel,
   input  logic [lps_pkg::GROUP_IN_W-1:0]   req_group_index,
   input  logic                             req_level,
   input  logic [lps_pkg::INTERVAL_W-1:0]   req_interval_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lps_pkg::OUT_W-1:0]        rsp_levels,
   output logic [lps_pkg::OUT_W-1:0]        rsp_active_mask
);
   import lps_pkg::*;

   push_type         push;
   queue_status_type q_status;
   item_type         head;
   logic             pop;

   lps_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_channel    (req_channel),
      .req_group_index(req_group_index),
      .req_level      (req_level),
      .req_interval_ms(req_interval_ms),
      .q_status       (q_status),
      .push           (push)
   );

   lps_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .head    (head),
      .q_status(q_status)
   );

   lps_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_levels     (rsp_levels),
      .rsp_active_mask(rsp_active_mask)
   );

`ifndef SYNTHESIS
   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.valid)
      else $error("back end took an item from an empty queue");

   a_empty_stays_empty: assert property (@(posedge clock) disable iff (reset)
      (!q_status.valid && !push.push) |=> !q_status.valid)
      else $error("queue filled without a transfer");

   a_full_blocks_push: assert property (@(posedge clock) disable iff (reset)
      (q_status.full && !pop) |=> q_status.full)
      else $error("full queue drained without a pop");
`endif

endmodule

>>> sim/tb_led_pattern_sequencer.sv
module tb_led_pattern_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   typedef struct {
      bit [FUNC_W-1:0]     func;
      bit [CHAN_IN_W-1:0]  channel;
      bit [GROUP_IN_W-1:0] group;
      bit                  level;
      bit [INTERVAL_W-1:0] interval;
   } led_cmd_type;

   typedef struct {
      bit [OUT_W-1:0] levels;
      bit [OUT_W-1:0] active;
   } led_view_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FUNC_W-1:0]     req_func = FUNC_NONE;
   logic [CHAN_IN_W-1:0]  req_channel = '0;
   logic [GROUP_IN_W-1:0] req_group_index = '0;
   logic                  req_level = 1'b0;
   logic [INTERVAL_W-1:0] req_interval_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [OUT_W-1:0]      rsp_levels;
   logic [OUT_W-1:0]      rsp_active_mask;

   led_pattern_sequencer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_channel     (req_channel),
      .req_group_index (req_group_index),
      .req_level       (req_level),
      .req_interval_ms (req_interval_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_levels      (rsp_levels),
      .rsp_active_mask (rsp_active_mask)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the sequencer: pattern memory and per-channel playback state.
   bit                    grp_level [PATTERN_GROUPS];
   bit [INTERVAL_W-1:0]   grp_dwell [PATTERN_GROUPS];
   bit [NUM_CHANNELS-1:0] run_mask;
   bit [NUM_CHANNELS-1:0] armed_mask;
   bit [NUM_CHANNELS-1:0] again_mask;
   bit [NUM_CHANNELS-1:0] led_bits;
   bit [GROUP_W-1:0]      start_grp [NUM_CHANNELS];
   bit [GROUP_W-1:0]      next_grp  [NUM_CHANNELS];
   bit [INTERVAL_W-1:0]   dwell_ms  [NUM_CHANNELS];
   bit [INTERVAL_W-1:0]   count_ms  [NUM_CHANNELS];

   led_cmd_type  cmd_q [$];
   led_view_type led_expect_q [$];
   led_cmd_type  drv_cmd;
   led_view_type seen_want;
   bit        grp_written [GROUP_ENTRIES];
   bit [GROUP_IN_W-1:0] last_base [1 << CHAN_IN_W];

   int queued_count = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int error_count = 0;
   int func_seen [4] = '{0, 0, 0, 0};
   int steps_seen = 0;
   int reloads_seen = 0;
   int stops_seen = 0;

   function automatic bit [GROUP_W-1:0] after_grp(bit [GROUP_W-1:0] g);
      return GROUP_W'((int'(g) + 1) % PATTERN_GROUPS);
   endfunction

   function automatic void reload_start(int c);
      bit [GROUP_W-1:0] g;
      g = start_grp[c];
      led_bits[c] = grp_level[g];
      dwell_ms[c] = grp_dwell[g];
      next_grp[c] = after_grp(g);
   endfunction

   function automatic void advance_channel(int c);
      bit [GROUP_W-1:0]    p;
      bit                  lv;
      bit [INTERVAL_W-1:0] d;
      p = next_grp[c];
      lv = grp_level[p];
      d = grp_dwell[p];
      next_grp[c] = after_grp(p);
      steps_seen++;
      if (d == 0) begin
         reload_start(c);
         reloads_seen++;
      end else if (d != STOP_MARK) begin
         dwell_ms[c] = d;
         led_bits[c] = lv;
      end else if (again_mask[c]) begin
         // A pending extra pass consumes the stop group and replays the pattern.
         again_mask[c] = 1'b0;
         reload_start(c);
         reloads_seen++;
      end else begin
         led_bits[c] = lv;
         run_mask[c] = 1'b0;
         armed_mask[c] = 1'b0;
         stops_seen++;
      end
   endfunction

   function automatic led_view_type next_led_view(led_cmd_type cmd);
      led_view_type     v;
      bit [GROUP_W-1:0] g;
      int               c;
      g = GROUP_W'(int'(cmd.group) % PATTERN_GROUPS);
      c = int'(cmd.channel);
      func_seen[cmd.func]++;
      case (cmd.func)
         FUNC_TICK: begin
            for (int n = 0; n < NUM_CHANNELS; n++) begin
               if (run_mask[n]) begin
                  if (count_ms[n] != STOP_MARK) count_ms[n] = count_ms[n] + 1;
                  if (count_ms[n] >= dwell_ms[n]) begin
                     count_ms[n] = '0;
                     advance_channel(n);
                  end
               end
            end
         end
         FUNC_START: begin
            if (c < NUM_CHANNELS) begin
               if (armed_mask[c] && start_grp[c] == g) begin
                  again_mask[c] = 1'b1;
               end else begin
                  start_grp[c] = g;
                  armed_mask[c] = 1'b1;
                  run_mask[c] = 1'b1;
                  count_ms[c] = '0;
                  reload_start(c);
               end
            end
         end
         FUNC_WRITE: begin
            grp_level[g] = cmd.level;
            grp_dwell[g] = cmd.interval;
         end
         default: ;
      endcase
      v.levels = OUT_W'(led_bits);
      v.active = OUT_W'(run_mask);
      return v;
   endfunction

   function automatic bit no_gap(int n);
      return n >= 600 && n < 800;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            led_expect_q.push_back(next_led_view(drv_cmd));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (cmd_q.size() == 0 || (!no_gap(accepted_count) && $urandom_range(99) < 32)) begin
               req_valid <= 1'b0;
            end else begin
               drv_cmd = cmd_q.pop_front();
               req_valid       <= 1'b1;
               req_func        <= drv_cmd.func;
               req_channel     <= drv_cmd.channel;
               req_group_index <= drv_cmd.group;
               req_level       <= drv_cmd.level;
               req_interval_ms <= drv_cmd.interval;
            end
         end
      end
   end

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch on result %0d, %s: expected %h, got %h", checked_count, what,
                  want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (led_expect_q.size() == 0) begin
               report_mismatch("unexpected transfer, levels", '0, rsp_levels);
            end else begin
               seen_want = led_expect_q.pop_front();
               if (rsp_levels !== seen_want.levels) begin
                  report_mismatch("levels", seen_want.levels, rsp_levels);
               end
               if (rsp_active_mask !== seen_want.active) begin
                  report_mismatch("active_mask", seen_want.active, rsp_active_mask);
               end
            end
            checked_count++;
         end
         rsp_stall <= !no_gap(checked_count) && ($urandom_range(99) < 32);
      end
   end

   function automatic led_cmd_type noise_cmd(bit [FUNC_W-1:0] f);
      led_cmd_type c;
      c.func = f;
      c.channel = CHAN_IN_W'($urandom);
      c.group = GROUP_IN_W'($urandom);
      c.level = 1'($urandom);
      c.interval = $urandom;
      return c;
   endfunction

   function automatic void push_cmd(led_cmd_type c);
      cmd_q.push_back(c);
      queued_count++;
      if (c.func == FUNC_WRITE) grp_written[c.group] = 1'b1;
      if (c.func == FUNC_START) last_base[c.channel] = c.group;
   endfunction

   function automatic void push_tick();
      push_cmd(noise_cmd(FUNC_TICK));
   endfunction

   function automatic void push_start(bit [CHAN_IN_W-1:0] ch, bit [GROUP_IN_W-1:0] g);
      led_cmd_type c;
      c = noise_cmd(FUNC_START);
      c.channel = ch;
      c.group = g;
      push_cmd(c);
   endfunction

   function automatic void push_write(bit [GROUP_IN_W-1:0] g, bit lv,
                                      bit [INTERVAL_W-1:0] iv);
      led_cmd_type c;
      c = noise_cmd(FUNC_WRITE);
      c.group = g;
      c.level = lv;
      c.interval = iv;
      push_cmd(c);
   endfunction

   // Mostly short durations so that patterns actually step, with loop and
   // stop marks and the odd long one mixed in.
   function automatic bit [INTERVAL_W-1:0] pick_dwell();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 22) return STOP_MARK;
      if (r < 80) return $urandom_range(1, 4);
      if (r < 90) return $urandom_range(5, 40);
      return $urandom;
   endfunction

   task automatic wait_drained();
      while (accepted_count != queued_count || led_expect_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int                  pool [$];
      int                  j;
      int                  k;
      int                  tmp;
      int                  r;
      bit [CHAN_IN_W-1:0]  ch;
      bit [GROUP_IN_W-1:0] g;
      led_cmd_type         c;

      // Directed: empty tick, idle code with every field at its top, a loop
      // that wraps the memory, a first group that holds forever, a first group
      // of zero length, repeat requests and a restart on another group.
      push_tick();
      c = noise_cmd(FUNC_NONE);
      c.channel = '1;
      c.group = '1;
      c.level = 1'b1;
      c.interval = '1;
      push_cmd(c);
      push_write(8'd254, 1'b1, 32'd2);
      push_write(8'd255, 1'b0, 32'd1);
      push_write(8'd0, 1'b1, 32'd0);
      push_write(8'd10, 1'b1, STOP_MARK);
      push_write(8'd11, 1'b0, STOP_MARK);
      push_write(8'd20, 1'b1, 32'd0);
      push_write(8'd21, 1'b0, STOP_MARK);
      push_write(8'd30, 1'b1, 32'd1);
      push_write(8'd31, 1'b0, STOP_MARK);
      push_write(8'd40, 1'b1, 32'hFFFF_FFFE);
      push_start(3'd0, 8'd254);
      push_start(3'd7, 8'd10);
      push_start(3'd3, 8'd20);
      push_start(3'd5, 8'd30);
      push_start(3'd5, 8'd30);
      repeat (4) push_tick();
      push_start(3'd0, 8'd254);
      push_start(3'd0, 8'd30);
      repeat (2) push_tick();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Let the directed part settle completely before the sender resumes.
      wait_drained();

      // Fill the rest of the pattern memory in random order so that any later
      // playback only ever reads written groups.
      for (j = 0; j < GROUP_ENTRIES; j++) begin
         if (!grp_written[j]) pool.push_back(j);
      end
      for (j = pool.size() - 1; j > 0; j--) begin
         k = $urandom_range(j);
         tmp = pool[j];
         pool[j] = pool[k];
         pool[k] = tmp;
      end
      foreach (pool[j]) begin
         if ($urandom_range(99) < 25) push_tick();
         push_write(GROUP_IN_W'(pool[j]), 1'($urandom), pick_dwell());
      end

      while (queued_count < 1225) begin
         r = $urandom_range(99);
         ch = CHAN_IN_W'($urandom_range(NUM_CHANNELS - 1));
         g = GROUP_IN_W'($urandom);
         if (r < 45) begin
            push_tick();
         end else if (r < 60) begin
            push_start(ch, ($urandom_range(99) < 40) ? last_base[ch] : g);
         end else if (r < 72) begin
            push_write(g, 1'($urandom), pick_dwell());
         end else if (r < 76) begin
            push_cmd(noise_cmd(FUNC_NONE));
         end else begin
            // A fresh short pattern ending in a loop or stop mark, then started.
            k = $urandom_range(1, 4);
            for (j = 0; j < k; j++) begin
               push_write(GROUP_IN_W'(g + j), 1'($urandom), $urandom_range(1, 3));
            end
            push_write(GROUP_IN_W'(g + k), 1'($urandom), $urandom_range(1) ? STOP_MARK : '0);
            push_start(ch, g);
            if ($urandom_range(99) < 30) push_start(ch, g);
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);

      $display("run covered %0d transfers: %0d ticks, %0d starts, %0d writes, %0d idle codes",
               accepted_count, func_seen[FUNC_TICK], func_seen[FUNC_START],
               func_seen[FUNC_WRITE], func_seen[FUNC_NONE]);
      $display("channel steps %0d, start group reloads %0d, stops %0d, mismatches %0d",
               steps_seen, reloads_seen, stops_seen, error_count);
      if (error_count == 0 && led_expect_q.size() == 0) begin
         $display("tb_led_pattern_sequencer: clean");
      end else begin
         $display("tb_led_pattern_sequencer: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_led_pattern_sequencer: errors");
      $finish;
   end

endmodule
